// ----- hdl/wts_pkg.sv -----
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam int DIM_W   = 14;
  localparam int COEF_W  = 32;

  // Register indexes (byte address is 8 times the index).
  localparam logic [2:0] REG_ROW0_XY = 3'd0;
  localparam logic [2:0] REG_ROW0_ZW = 3'd1;
  localparam logic [2:0] REG_ROW1_XY = 3'd2;
  localparam logic [2:0] REG_ROW1_ZW = 3'd3;
  localparam logic [2:0] REG_ROW3_XY = 3'd4;
  localparam logic [2:0] REG_ROW3_ZW = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  localparam logic [63:0] RST_ROW0_XY = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RST_ROW0_ZW = 64'h0;
  localparam logic [63:0] RST_ROW1_XY = 64'h0001_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_ZW = 64'h0;
  localparam logic [63:0] RST_ROW3_XY = 64'h0;
  localparam logic [63:0] RST_ROW3_ZW = 64'h0001_0000_0000_0000;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 14'd1920;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 14'd1080;

  typedef struct packed {
    logic [63:0]      row0_xy;
    logic [63:0]      row0_zw;
    logic [63:0]      row1_xy;
    logic [63:0]      row1_zw;
    logic [63:0]      row3_xy;
    logic [63:0]      row3_zw;
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
  } cfg_t;

  // Per-item flags that ride alongside the divider pipeline.
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage

`default_nettype wire

// ----- hdl/point_if.sv -----
// ----------------------------------------------------------------------------
// point_if
// Valid/ready channel carrying one world point per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface point_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ----- hdl/screen_if.sv -----
// ----------------------------------------------------------------------------
// screen_if
// Valid/ready channel carrying one projected screen position per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface screen_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          on_screen;
  logic signed [COORD_WIDTH-1:0] screen_x;
  logic signed [COORD_WIDTH-1:0] screen_y;

  modport source (output valid, on_screen, screen_x, screen_y, input ready);
  modport sink   (input valid, on_screen, screen_x, screen_y, output ready);
endinterface

`default_nettype wire

// ----- hdl/wts_regs.sv -----
// ----------------------------------------------------------------------------
// wts_regs
// APB register file holding the matrix rows and the screen size.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wts_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [wts_pkg::PDATA_W-1:0]  pwdata,
  output logic      [wts_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output wts_pkg::cfg_t                     cfg
);
  import wts_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[PADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row0_xy       <= RST_ROW0_XY;
      cfg.row0_zw       <= RST_ROW0_ZW;
      cfg.row1_xy       <= RST_ROW1_XY;
      cfg.row1_zw       <= RST_ROW1_ZW;
      cfg.row3_xy       <= RST_ROW3_XY;
      cfg.row3_zw       <= RST_ROW3_ZW;
      cfg.screen_width  <= RST_WIDTH;
      cfg.screen_height <= RST_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        REG_ROW0_XY: cfg.row0_xy       <= pwdata;
        REG_ROW0_ZW: cfg.row0_zw       <= pwdata;
        REG_ROW1_XY: cfg.row1_xy       <= pwdata;
        REG_ROW1_ZW: cfg.row1_zw       <= pwdata;
        REG_ROW3_XY: cfg.row3_xy       <= pwdata;
        REG_ROW3_ZW: cfg.row3_zw       <= pwdata;
        REG_WIDTH:   cfg.screen_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT:  cfg.screen_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW0_XY: prdata = cfg.row0_xy;
      REG_ROW0_ZW: prdata = cfg.row0_zw;
      REG_ROW1_XY: prdata = cfg.row1_xy;
      REG_ROW1_ZW: prdata = cfg.row1_zw;
      REG_ROW3_XY: prdata = cfg.row3_xy;
      REG_ROW3_ZW: prdata = cfg.row3_zw;
      REG_WIDTH:   prdata = PDATA_W'(cfg.screen_width);
      REG_HEIGHT:  prdata = PDATA_W'(cfg.screen_height);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/wts_rows.sv -----
// ----------------------------------------------------------------------------
// wts_rows
// Two-stage matrix row evaluation: nine registered products, then three sums.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_rows #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32,
  parameter int SUM_W       = 82
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COORD_WIDTH-1:0] px,
  input  wire logic signed [COORD_WIDTH-1:0] py,
  input  wire logic signed [COORD_WIDTH-1:0] pz,
  input  wts_pkg::cfg_t                      cfg,
  output logic signed [SUM_W-1:0]            w,
  output logic signed [SUM_W-1:0]            n,
  output logic signed [SUM_W-1:0]            m
);
  import wts_pkg::*;

  localparam int PW = COORD_WIDTH + COEF_W;

  logic signed [PW-1:0] p0x, p0y, p0z, p1x, p1y, p1z, p3x, p3y, p3z;

  function automatic logic signed [COEF_W-1:0] lo_half(input logic [63:0] r);
    return $signed(r[31:0]);
  endfunction

  function automatic logic signed [COEF_W-1:0] hi_half(input logic [63:0] r);
    return $signed(r[63:32]);
  endfunction

  function automatic logic signed [SUM_W-1:0] sum4(
    input logic signed [PW-1:0] a,
    input logic signed [PW-1:0] b,
    input logic signed [PW-1:0] c,
    input logic signed [COEF_W-1:0] off
  );
    return SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + (SUM_W'(off) <<< FRAC_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p0x <= lo_half(cfg.row0_xy) * px;
      p0y <= hi_half(cfg.row0_xy) * py;
      p0z <= lo_half(cfg.row0_zw) * pz;
      p1x <= lo_half(cfg.row1_xy) * px;
      p1y <= hi_half(cfg.row1_xy) * py;
      p1z <= lo_half(cfg.row1_zw) * pz;
      p3x <= lo_half(cfg.row3_xy) * px;
      p3y <= hi_half(cfg.row3_xy) * py;
      p3z <= lo_half(cfg.row3_zw) * pz;
    end
  end

  // Offsets read live; user must write them only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (en) begin
      n <= sum4(p0x, p0y, p0z, hi_half(cfg.row0_zw));
      m <= sum4(p1x, p1y, p1z, hi_half(cfg.row1_zw));
      w <= sum4(p3x, p3y, p3z, hi_half(cfg.row3_zw));
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wts_div.sv -----
// ----------------------------------------------------------------------------
// wts_div
// Pipelined restoring divider: an overflow stage, then one quotient bit per
// stage, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_div #(
  parameter int NUM_W = 113,
  parameter int DEN_W = 82,
  parameter int QW    = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QW-1:0]    quo,
  output logic                  ovf
);
  localparam int RW = ((NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW) + 1;

  logic [RW-1:0]    r  [0:QW];
  logic [DEN_W-1:0] d  [0:QW];
  logic [QW-1:0]    q  [0:QW];
  logic             ov [0:QW];

  // Quotient of 2^QW or more cannot be represented: flag it and saturate later.
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= RW'(num);
      d[0]  <= den;
      q[0]  <= '0;
      ov[0] <= RW'(num) >= (RW'(den) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int SH = QW - k;
    logic [RW-1:0] dsh;
    logic          ge;

    always_comb begin
      dsh = RW'(d[k-1]) << SH;
      ge  = r[k-1] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[k]  <= ge ? r[k-1] - dsh : r[k-1];
        q[k]  <= ge ? (q[k-1] | (QW'(1) << SH)) : q[k-1];
        d[k]  <= d[k-1];
        ov[k] <= ov[k-1];
      end
    end
  end

  assign quo = q[QW];
  assign ovf = ov[QW];

endmodule

`default_nettype wire

// ----- hdl/world_to_screen_projection.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of world points to screen coordinates.
// ----------------------------------------------------------------------------
// Takes one point per clock while the output side does not stall, and returns
// one result per point, in order. The two dividers resolve one quotient bit
// per stage; the front end spends two stages on the matrix rows, one on the
// visibility test and numerators, and one on the screen-size scaling. A stall
// at the output freezes the whole pipeline. Matrix rows and screen size must
// only be written while no point is in flight.
`default_nettype none

module world_to_screen_projection #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  point_if.sink                             point,
  screen_if.source                          screen,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wts_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [wts_pkg::PDATA_W-1:0]  pwdata,
  output logic      [wts_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import wts_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int SW  = CW + COEF_W + FRAC_BITS + 2;
  localparam int MW  = SW + 1;
  localparam int NW  = MW + DIM_W + FRAC_BITS;
  localparam int L   = CW + 6;
  localparam int HW  = SW + 7;

  cfg_t cfg;
  logic en;
  logic [L-1:0] v;

  logic signed [SW-1:0] w, n, m;
  logic z1, z2;

  // Numerator and visibility stage.
  logic signed [SW:0]   a_sum, b_sum;
  logic signed [HW-1:0] w100;
  side_t                sb3, sb3_next;
  logic [MW-1:0]        mag_a, mag_b;
  logic [SW-1:0]        den3;

  // Scaling stage.
  side_t         sb4;
  logic [NW-1:0] num_x, num_y;
  logic [SW-1:0] den4;

  side_t         sbd [0:CW];
  logic [CW-1:0] qx, qy;
  logic          ovx, ovy;

  logic              on_o;
  logic [CW-1:0]     x_o, y_o;

  wts_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign en          = !v[L-1] || screen.ready;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[L-2:0], point.valid};
    end
  end

  wts_rows #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(CW),
    .SUM_W      (SW)
  ) u_rows (
    .clk, .en,
    .px (point.point_x),
    .py (point.point_y),
    .pz (point.point_z),
    .cfg,
    .w, .n, .m
  );

  always_ff @(posedge clk) begin
    if (en) begin
      z1 <= (point.point_x == '0) && (point.point_y == '0) && (point.point_z == '0);
      z2 <= z1;
    end
  end

  always_comb begin
    a_sum = (SW+1)'(w) + (SW+1)'(n);
    b_sum = (SW+1)'(w) - (SW+1)'(m);
    w100  = (HW'(w) <<< 6) + (HW'(w) <<< 5) + (HW'(w) <<< 2);
    // Visible when w is at least 0.01, tested exactly as 100 * w >= 1.0.
    sb3_next.vis   = !z2 && !w[SW-1] &&
                     ($unsigned(w100) >= (HW'(1) << (2 * FRAC_BITS)));
    sb3_next.neg_x = a_sum[SW];
    sb3_next.neg_y = b_sum[SW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3   <= sb3_next;
      mag_a <= a_sum[SW] ? MW'(-a_sum) : MW'(a_sum);
      mag_b <= b_sum[SW] ? MW'(-b_sum) : MW'(b_sum);
      den3  <= {w[SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb4   <= sb3;
      den4  <= den3;
      num_x <= (NW'(mag_a) * NW'(cfg.screen_width)) << FRAC_BITS;
      num_y <= (NW'(mag_b) * NW'(cfg.screen_height)) << FRAC_BITS;
    end
  end

  wts_div #(.NUM_W(NW), .DEN_W(SW), .QW(CW)) u_div_x (
    .clk, .en, .num(num_x), .den(den4), .quo(qx), .ovf(ovx)
  );

  wts_div #(.NUM_W(NW), .DEN_W(SW), .QW(CW)) u_div_y (
    .clk, .en, .num(num_y), .den(den4), .quo(qy), .ovf(ovy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[0] <= sb4;
    end
  end

  for (genvar k = 1; k <= CW; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sbd[k] <= sbd[k-1];
      end
    end
  end

  // Signed result from magnitude quotient, saturated to the coordinate range.
  function automatic logic [CW-1:0] sat(
    input logic          neg,
    input logic          ov,
    input logic [CW-1:0] q
  );
    logic [CW-1:0] lim;
    lim = CW'(1) << (CW - 1);
    if (neg) begin
      return (ov || q > lim) ? lim : CW'(-q);
    end
    return (ov || q >= lim) ? lim - CW'(1) : q;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      on_o <= sbd[CW].vis;
      x_o  <= sbd[CW].vis ? sat(sbd[CW].neg_x, ovx, qx) : '0;
      y_o  <= sbd[CW].vis ? sat(sbd[CW].neg_y, ovy, qy) : '0;
    end
  end

  assign screen.valid     = v[L-1];
  assign screen.on_screen = on_o;
  assign screen.screen_x  = $signed(x_o);
  assign screen.screen_y  = $signed(y_o);

`ifndef SYNTHESIS
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (screen.valid && !screen.on_screen) |-> (screen.screen_x == '0 && screen.screen_y == '0))
    else $error("hidden point with nonzero screen position");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !screen.valid)
    else $error("result present right after reset");

  a_rise_moves: assert property (@(posedge clk) disable iff (rst)
    $rose(screen.valid) |-> $past(en))
    else $error("result appeared while the pipeline was stalled");
`endif

endmodule

`default_nettype wire

// ----- verif/world_to_screen_projection_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_test
// Self-checking bench for the world-to-screen projection block. Loads several
// matrix and screen settings over the register port, streams world points in
// with random gaps while the result side stalls at random, and compares every
// projected position with a hand-typed value or an in-bench fixed-point projection of the point.
// ----------------------------------------------------------------------------

module world_to_screen_projection_test;
  import wts_pkg::*;

  localparam int LATENCY   = 38;
  localparam int MAX_CYCLE = 300000;
  localparam int N_PHASES  = 10;
  localparam int PHASE_PTS = 130;

  typedef struct packed {
    logic        on;
    logic [31:0] sx;
    logic [31:0] sy;
  } screen_pos_t;

  typedef struct packed {
    logic        persp;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        known;
    screen_pos_t res;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  point_if  #(.COORD_WIDTH(32)) pt ();
  screen_if #(.COORD_WIDTH(32)) scr ();

  cfg_t        matrix;
  screen_pos_t pending_pos[$];
  int          n_errors = 0;
  int          n_points = 0;
  int          n_results = 0;
  int          cycle = 0;
  logic        calm = 1'b0;

  world_to_screen_projection #(.FRAC_BITS(16), .COORD_WIDTH(32)) u_dut (
    .clk(clk), .rst(rst), .point(pt.sink), .screen(scr.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  initial begin
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    scr.ready = 1'b0;
  end

  // Row sum with 32 fraction bits; the offset is shifted up to match.
  function automatic logic signed [127:0] row_dot(logic [63:0] xy, logic [63:0] zw,
                                                  logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
    logic signed [127:0] cx, cy, cz, off, ax, ay, az;
    cx = $signed(xy[31:0]);
    cy = $signed(xy[63:32]);
    cz = $signed(zw[31:0]);
    off = $signed(zw[63:32]);
    ax = px;
    ay = py;
    az = pz;
    return cx * ax + cy * ay + cz * az + (off <<< 16);
  endfunction

  // dim * num / (2w), truncated toward zero and saturated to 32 bits.
  function automatic logic [31:0] to_screen(logic signed [127:0] num,
                                            logic [DIM_W-1:0] dim,
                                            logic [127:0] w);
    logic        neg;
    logic [127:0] mag, q, d;
    neg = num[127];
    mag = neg ? -num : num;
    d = dim;
    mag = (mag * d) << 16;
    q = mag / (w << 1);
    if (neg) begin
      if (q > 128'h8000_0000) return 32'h8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic screen_pos_t project_point(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz);
    screen_pos_t r;
    logic signed [127:0] w, n, m;
    r = '0;
    if (px == 0 && py == 0 && pz == 0) return r;
    w = row_dot(matrix.row3_xy, matrix.row3_zw, px, py, pz);
    if (w < 0) return r;
    if (128'd100 * w < (128'd1 << 32)) return r;
    n = row_dot(matrix.row0_xy, matrix.row0_zw, px, py, pz);
    m = row_dot(matrix.row1_xy, matrix.row1_zw, px, py, pz);
    r.on = 1'b1;
    r.sx = to_screen(w + n, matrix.screen_width, w);
    r.sy = to_screen(w - m, matrix.screen_height, w);
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_check(logic [2:0] idx, logic [63:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'(idx) << 3;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("readback reg %0d: expected %h, got %h", idx, want, prdata);
      n_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_matrix(cfg_t c);
    matrix = c;
    reg_write(REG_ROW0_XY, c.row0_xy);
    reg_write(REG_ROW0_ZW, c.row0_zw);
    reg_write(REG_ROW1_XY, c.row1_xy);
    reg_write(REG_ROW1_ZW, c.row1_zw);
    reg_write(REG_ROW3_XY, c.row3_xy);
    reg_write(REG_ROW3_ZW, c.row3_zw);
    reg_write(REG_WIDTH, 64'(c.screen_width));
    reg_write(REG_HEIGHT, 64'(c.screen_height));
    reg_check(REG_ROW3_ZW, c.row3_zw);
    reg_check(REG_WIDTH, 64'(c.screen_width));
  endtask

  // Let the pipeline drain before touching the registers.
  task automatic drain();
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic known, screen_pos_t typed);
    while (!calm && $urandom_range(99) < 36) begin
      pt.valid <= 1'b0;
      @(posedge clk);
    end
    pt.valid <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.point_z <= z;
    @(posedge clk);
    while (!pt.ready) @(posedge clk);
    pending_pos.push_back(known ? typed : project_point(x, y, z));
    n_points++;
  endtask

  function automatic logic [31:0] mild_coef();
    return 32'($signed(int'($urandom_range(0, 1 << 18))) - (1 << 17));
  endfunction

  function automatic logic [31:0] coord_pick();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      4, 5:       return $urandom;
      6:          return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    return 32'(int'($urandom_range(0, 2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  function automatic cfg_t pick_matrix(int kind);
    cfg_t c;
    c.row0_xy = {mild_coef(), mild_coef()};
    c.row0_zw = {mild_coef(), mild_coef()};
    c.row1_xy = {mild_coef(), mild_coef()};
    c.row1_zw = {mild_coef(), mild_coef()};
    c.row3_xy = {32'(int'($urandom_range(0, 1 << 14)) - (1 << 13)),
                 32'(int'($urandom_range(0, 1 << 14)) - (1 << 13))};
    c.row3_zw = {32'(int'($urandom_range(0, 1 << 17)) - (1 << 16)), 32'h0001_0000};
    c.screen_width = DIM_W'($urandom_range(1, 8192));
    c.screen_height = DIM_W'($urandom_range(1, 8192));
    case (kind)
      1: begin
        c.row0_xy = {32'h7FFF_FFFF, 32'h8000_0000};
        c.row0_zw = {32'h8000_0000, 32'h7FFF_FFFF};
        c.row1_xy = {32'h8000_0000, 32'h7FFF_FFFF};
        c.row1_zw = {32'h7FFF_FFFF, 32'h8000_0000};
        c.row3_zw = {32'h0000_0000, 32'h7FFF_FFFF};
        c.screen_width = DIM_W'(8192);
        c.screen_height = DIM_W'(1);
      end
      2: begin
        c.row3_xy = '0;
        c.row3_zw = {32'h0, 32'h0001_0000};
        c.screen_width = DIM_W'(1);
        c.screen_height = DIM_W'(8192);
      end
      3: begin
        c.row0_xy = {$urandom, $urandom};
        c.row0_zw = {$urandom, $urandom};
        c.row1_xy = {$urandom, $urandom};
        c.row1_zw = {$urandom, $urandom};
        c.row3_xy = {$urandom, $urandom};
        c.row3_zw = {$urandom, $urandom};
      end
      default: ;
    endcase
    return c;
  endfunction

  // The result side stalls at random except during the calm stretch.
  always @(posedge clk) begin
    scr.ready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    screen_pos_t want;
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("Timed out after %0d cycles", cycle);
      $display("Some tests failed");
      $finish;
    end
    if (!rst && scr.valid && scr.ready) begin
      n_results++;
      if (pending_pos.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        want = pending_pos.pop_front();
        if (scr.on_screen !== want.on) begin
          $error("on_screen: expected %0b, got %0b", want.on, scr.on_screen);
          n_errors++;
        end
        if (scr.screen_x !== want.sx) begin
          $error("screen_x: expected %h, got %h", want.sx, scr.screen_x);
          n_errors++;
        end
        if (scr.screen_y !== want.sy) begin
          $error("screen_y: expected %h, got %h", want.sy, scr.screen_y);
          n_errors++;
        end
      end
    end
  end

  initial begin
    probe_t probes[18];
    cfg_t   base, persp;
    logic   in_persp;
    logic [31:0] x, y, z;
    int     kinds[N_PHASES];

    kinds = '{0, 1, 2, 3, 0, 2, 1, 0, 2, 3};
    base = '{RST_ROW0_XY, RST_ROW0_ZW, RST_ROW1_XY, RST_ROW1_ZW,
             RST_ROW3_XY, RST_ROW3_ZW, RST_WIDTH, RST_HEIGHT};
    persp = base;
    persp.row3_zw = {32'h0, 32'h0001_0000};

    // Reset matrix: w is 1.0, so screen x is width * (1 + x) / 2 and screen y is height * (1 - y) / 2.
    probes[0]  = '{1'b0, 32'h0, 32'h0, 32'h0, 1'b1, '{1'b0, 32'h0, 32'h0}};
    probes[1]  = '{1'b0, 32'h0001_0000, 32'h0, 32'h0, 1'b1,
                   '{1'b1, 32'h0780_0000, 32'h021C_0000}};
    probes[2]  = '{1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1,
                   '{1'b1, 32'h7FFF_FFFF, 32'h021C_0000}};
    probes[3]  = '{1'b0, 32'h8000_0000, 32'h0, 32'h0, 1'b1,
                   '{1'b1, 32'h8000_0000, 32'h021C_0000}};
    probes[4]  = '{1'b0, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b1,
                   '{1'b1, 32'h03C0_0000, 32'h8000_0000}};
    probes[5]  = '{1'b0, 32'h0, 32'h8000_0000, 32'h0, 1'b1,
                   '{1'b1, 32'h03C0_0000, 32'h7FFF_FFFF}};
    probes[6]  = '{1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1,
                   '{1'b1, 32'h03C0_0000, 32'h021C_0000}};
    probes[7]  = '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b1,
                   '{1'b1, 32'h03C0_0000, 32'h021C_0000}};
    probes[8]  = '{1'b0, 32'hFFFF_0000, 32'h0, 32'h0, 1'b1,
                   '{1'b1, 32'h0, 32'h021C_0000}};
    probes[9]  = '{1'b0, 32'h1, 32'h1, 32'h1, 1'b0, '0};
    probes[10] = '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0};
    probes[11] = '{1'b0, 32'h1234_5678, 32'hEDCB_A987, 32'h0ABC_DEF0, 1'b0, '0};
    // Depth camera: w follows z, so the 0.01 threshold sits between 655 and 656.
    probes[12] = '{1'b1, 32'h0, 32'h0, 32'd656, 1'b0, '0};
    probes[13] = '{1'b1, 32'h0, 32'h0, 32'd655, 1'b1, '0};
    probes[14] = '{1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, '0};
    probes[15] = '{1'b1, 32'h0001_0000, 32'h0, 32'h0, 1'b1, '0};
    probes[16] = '{1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, '0};
    probes[17] = '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0};

    matrix = base;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    load_matrix(base);
    in_persp = 1'b0;

    foreach (probes[i]) begin
      if (probes[i].persp != in_persp) begin
        pt.valid <= 1'b0;
        drain();
        load_matrix(persp);
        in_persp = probes[i].persp;
      end
      send_point(probes[i].x, probes[i].y, probes[i].z, probes[i].known, probes[i].res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      pt.valid <= 1'b0;
      drain();
      load_matrix(pick_matrix(kinds[ph]));
      for (int k = 0; k < PHASE_PTS; k++) begin
        calm = (ph == 4 && k >= 20 && k < 100);
        case ($urandom_range(11))
          0: begin
            x = 32'h0;
            y = 32'h0;
            z = $urandom_range(1) ? 32'h0 : 32'($urandom_range(1, 3));
          end
          1: begin
            // Depth near the visibility threshold, either sign.
            x = 32'h0;
            y = 32'h0;
            z = 32'(int'($urandom_range(0, 2000)) - 1000);
          end
          default: begin
            x = coord_pick();
            y = coord_pick();
            z = coord_pick();
          end
        endcase
        send_point(x, y, z, 1'b0, '0);
      end
    end
    calm = 1'b0;
    pt.valid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d points under %0d register settings, checked %0d results",
             n_points, N_PHASES + 2, n_results);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- world_to_screen_projection.f -----
hdl/wts_pkg.sv
hdl/point_if.sv
hdl/screen_if.sv
hdl/wts_regs.sv
hdl/wts_rows.sv
hdl/wts_div.sv
hdl/world_to_screen_projection.sv
verif/world_to_screen_projection_test.sv
